### rtl/kgram_rolling_fingerprint_macros.svh
// -----------------------------------------------------------------------------
// kgram_rolling_fingerprint_macros
// Assertion shorthands used by the fingerprint checker. Each expands to a
// concurrent assertion clocked by clk_i and disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef KGRAM_ROLLING_FINGERPRINT_MACROS_SVH
`define KGRAM_ROLLING_FINGERPRINT_MACROS_SVH

// same-cycle implication
`define KRF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kgram fingerprint check failed");

// next-cycle implication
`define KRF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kgram fingerprint check failed");

`endif

### rtl/krf_pkg.sv
// -----------------------------------------------------------------------------
// krf_pkg
// Widths, reset values, register indexes and modulo 2^61-1 helpers for the
// k-gram rolling fingerprint block.
// -----------------------------------------------------------------------------
`default_nettype none

package krf_pkg;

  localparam int DATA_W    = 61;
  localparam int CHAR_W    = 8;
  localparam int WLEN_W    = 7;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] MOD61 = {DATA_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_POW   = 2'd2;

  localparam logic [DATA_W-1:0] BASE_RST     = 61'd131;
  localparam logic [WLEN_W-1:0] WLEN_RST     = 7'd8;
  localparam logic [DATA_W-1:0] BASE_POW_RST = 61'd86730203469006241;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_WAIT   = 6'b000100,
    ST_TOKEN  = 6'b001000,
    ST_DIFF   = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_e;

  // register value of 2^61-1 acts as zero
  function automatic logic [DATA_W-1:0] fold_mod61(input logic [DATA_W-1:0] x);
    return (x == MOD61) ? '0 : x;
  endfunction

  function automatic logic [DATA_W-1:0] add_mod61(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD61}) begin
      s = s - {1'b0, MOD61};
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sub_mod61(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a - b + MOD61;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/krf_stream_if.sv
// -----------------------------------------------------------------------------
// krf_stream_if
// Valid/ready channels of the fingerprint block: character items in,
// fingerprint results out.
// -----------------------------------------------------------------------------
`default_nettype none

interface krf_in_if;
  logic                        valid;
  logic                        ready;
  logic [krf_pkg::CHAR_W-1:0]  char_code;
  logic                        char_valid;
  logic                        end_of_token;
  logic                        end_of_document;

  modport source (output valid, char_code, char_valid, end_of_token, end_of_document,
                  input ready);
  modport sink   (input valid, char_code, char_valid, end_of_token, end_of_document,
                  output ready);
endinterface

interface krf_out_if;
  logic                        valid;
  logic                        ready;
  logic [krf_pkg::DATA_W-1:0]  fingerprint;
  logic [krf_pkg::COUNT_W-1:0] window_start;
  logic                        document_end;

  modport source (output valid, fingerprint, window_start, document_end, input ready);
  modport sink   (input valid, fingerprint, window_start, document_end, output ready);
endinterface

`default_nettype wire

### rtl/krf_mul61.sv
// -----------------------------------------------------------------------------
// krf_mul61
// Pipelined multiplier modulo 2^61-1. Four partial products of the 32-bit and
// 29-bit operand halves, a full product stage and a fold stage; operands below
// 2^61-1, result registered by the fold stage, one new pair each cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module krf_mul61 (
  input  logic                       clk_i,
  input  logic [krf_pkg::DATA_W-1:0] a_i,
  input  logic [krf_pkg::DATA_W-1:0] b_i,
  output logic [krf_pkg::DATA_W-1:0] p_o
);
  import krf_pkg::*;

  localparam int PW = 2 * DATA_W;

  logic [63:0]         pp00_q;
  logic [60:0]         pp01_q;
  logic [60:0]         pp10_q;
  logic [57:0]         pp11_q;
  logic [PW-1:0]       prod_q;
  logic [PW-1:0]       prod_d;
  logic [DATA_W:0]     fold_sum;
  logic [DATA_W-1:0]   p_q;
  logic [DATA_W-1:0]   p_d;

  always_comb begin
    prod_d = PW'(pp00_q) + (PW'(pp01_q) << 32) + (PW'(pp10_q) << 32)
           + (PW'(pp11_q) << 64);
  end

  always_comb begin
    fold_sum = {1'b0, prod_q[DATA_W-1:0]} + {1'b0, prod_q[PW-1:DATA_W]};
    if (fold_sum >= {1'b0, MOD61}) begin
      p_d = DATA_W'(fold_sum - {1'b0, MOD61});
    end else begin
      p_d = fold_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pp00_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    pp01_q <= 61'(a_i[31:0]) * 61'(b_i[60:32]);
    pp10_q <= 61'(a_i[60:32]) * 61'(b_i[31:0]);
    pp11_q <= 58'(a_i[60:32]) * 58'(b_i[60:32]);
    prod_q <= prod_d;
    p_q    <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/kgram_rolling_fingerprint.sv
// -----------------------------------------------------------------------------
// kgram_rolling_fingerprint
// k-gram rolling fingerprint of a token stream modulo 2^61-1.
//
// item_i carries one character per transaction with its token-end and
// document-end flags; result_o carries a fingerprint, the window start index
// and a document-end flag. Both are valid/ready channels.
// cfg_we_i/cfg_idx_i/cfg_data_i write base, window length and base^k; write
// them only while no item is in flight.
// Each item walks the read, wait, token, diff and update states in order:
// ready is high only in the idle state, and the item is scheduled around
// the 3-stage modular multipliers and the token ring memory (read at accept,
// written in the last step). Its result enters the output register in that
// last step. The output register frees the input side: the next item is
// accepted while a result waits. If the previous result is still not taken
// when a new one is ready, the sequencer holds in its last step until it is.
// Reset restores the register defaults and clears the running hashes, ring
// position and token count; the ring memory is not cleared.
// -----------------------------------------------------------------------------
`default_nettype none

module kgram_rolling_fingerprint #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  krf_in_if.sink                        item_i,
  krf_out_if.source                     result_o,
  input  logic                          cfg_we_i,
  input  logic [krf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [krf_pkg::DATA_W-1:0]    cfg_data_i
);
  import krf_pkg::*;

  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW = ($clog2(MAX_WINDOW + 1) > WLEN_W) ? $clog2(MAX_WINDOW + 1) : WLEN_W;

  state_e state_q, state_d;

  logic [DATA_W-1:0]  base_q, base_d;
  logic [WLEN_W-1:0]  wlen_q, wlen_d;
  logic [DATA_W-1:0]  bpow_q, bpow_d;

  logic [DATA_W-1:0]  token_accum_q, token_accum_d;
  logic [DATA_W-1:0]  window_accum_q, window_accum_d;
  logic [SW-1:0]      ring_slot_q, ring_slot_d;
  logic [COUNT_W-1:0] tokens_seen_q, tokens_seen_d;
  logic               out_valid_q, out_valid_d;

  logic [CHAR_W-1:0]  char_code_q;
  logic               char_valid_q;
  logic               eot_q;
  logic               eod_q;
  logic [SW-1:0]      slot_eff_q, slot_eff_d;
  logic [DATA_W-1:0]  wprod_q, wprod_d;
  logic [DATA_W-1:0]  diff_q, diff_d;
  logic [DATA_W-1:0]  fp_q, fp_d;
  logic [COUNT_W-1:0] start_q, start_d;
  logic               docend_q, docend_d;

  logic [DATA_W-1:0]  ring_q [MAX_WINDOW];
  logic [DATA_W-1:0]  ring_rdata_q;

  logic [DATA_W-1:0]  base_eff;
  logic [DATA_W-1:0]  bpow_eff;
  logic [KW-1:0]      k_raw;
  logic [KW-1:0]      k;
  logic [SW-1:0]      slot_now;
  logic [DATA_W-1:0]  mul0_p;
  logic [DATA_W-1:0]  mul1_a;
  logic [DATA_W-1:0]  mul1_b;
  logic [DATA_W-1:0]  mul1_p;
  logic [DATA_W-1:0]  tok_hash;
  logic               in_fire;
  logic               emit;
  logic               upd_go;
  logic               ring_we;

  assign base_eff = fold_mod61(base_q);
  assign bpow_eff = fold_mod61(bpow_q);

  assign k_raw = KW'(wlen_q);
  always_comb begin
    if (wlen_q == '0) begin
      k = KW'(1);
    end else if (k_raw > KW'(MAX_WINDOW)) begin
      k = KW'(MAX_WINDOW);
    end else begin
      k = k_raw;
    end
  end

  assign slot_now = (32'(ring_slot_q) >= 32'(k)) ? '0 : ring_slot_q;

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_fire      = item_i.valid && item_i.ready;

  // unit 0: token * base; unit 1: window * base, then base^k * oldest
  assign mul1_a = (state_q == ST_READ) ? ring_rdata_q : window_accum_q;
  assign mul1_b = (state_q == ST_READ) ? bpow_eff : base_eff;

  krf_mul61 u_mul_tok (
    .clk_i (clk_i),
    .a_i   (token_accum_q),
    .b_i   (base_eff),
    .p_o   (mul0_p)
  );

  krf_mul61 u_mul_win (
    .clk_i (clk_i),
    .a_i   (mul1_a),
    .b_i   (mul1_b),
    .p_o   (mul1_p)
  );

  assign tok_hash = (token_accum_q == '0) ? DATA_W'(1) : token_accum_q;
  assign emit     = eot_q && (({1'b0, tokens_seen_q} + 33'd1) >= 33'(k));
  assign upd_go   = (state_q == ST_UPDATE) && !(emit && out_valid_q && !result_o.ready);
  assign ring_we  = upd_go && eot_q;

  always_comb begin
    base_d = base_q;
    wlen_d = wlen_q;
    bpow_d = bpow_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE:       base_d = cfg_data_i;
        REG_WINDOW_LEN: wlen_d = cfg_data_i[WLEN_W-1:0];
        REG_BASE_POW:   bpow_d = cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_comb begin
    state_d        = state_q;
    token_accum_d  = token_accum_q;
    window_accum_d = window_accum_q;
    ring_slot_d    = ring_slot_q;
    tokens_seen_d  = tokens_seen_q;
    slot_eff_d     = slot_eff_q;
    wprod_d        = wprod_q;
    diff_d         = diff_q;
    fp_d           = fp_q;
    start_d        = start_q;
    docend_d       = docend_q;
    out_valid_d    = out_valid_q && !result_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          slot_eff_d = slot_now;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        state_d = ST_TOKEN;
      end
      ST_TOKEN: begin
        if (char_valid_q) begin
          token_accum_d = add_mod61(mul0_p, DATA_W'(char_code_q) + DATA_W'(1));
        end
        wprod_d = mul1_p;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        if (tokens_seen_q >= COUNT_W'(k)) begin
          diff_d = sub_mod61(wprod_q, mul1_p);
        end else begin
          diff_d = wprod_q;
        end
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) begin
          if (eot_q) begin
            window_accum_d = add_mod61(diff_q, tok_hash);
            ring_slot_d    = (32'(slot_eff_q) + 32'd1 >= 32'(k)) ? '0 : slot_eff_q + 1'b1;
            tokens_seen_d  = (tokens_seen_q == '1) ? '1 : tokens_seen_q + 1'b1;
            token_accum_d  = '0;
            if (emit) begin
              fp_d        = add_mod61(diff_q, tok_hash);
              start_d     = (tokens_seen_q == '1) ? '1
                          : tokens_seen_q + COUNT_W'(1) - COUNT_W'(k);
              docend_d    = eod_q;
              out_valid_d = 1'b1;
            end
          end
          if (eod_q) begin
            token_accum_d  = '0;
            window_accum_d = '0;
            ring_slot_d    = '0;
            tokens_seen_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      base_q         <= BASE_RST;
      wlen_q         <= WLEN_RST;
      bpow_q         <= BASE_POW_RST;
      token_accum_q  <= '0;
      window_accum_q <= '0;
      ring_slot_q    <= '0;
      tokens_seen_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      base_q         <= base_d;
      wlen_q         <= wlen_d;
      bpow_q         <= bpow_d;
      token_accum_q  <= token_accum_d;
      window_accum_q <= window_accum_d;
      ring_slot_q    <= ring_slot_d;
      tokens_seen_q  <= tokens_seen_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_code_q  <= item_i.char_code;
      char_valid_q <= item_i.char_valid;
      eot_q        <= item_i.end_of_token;
      eod_q        <= item_i.end_of_document;
    end
    slot_eff_q <= slot_eff_d;
    wprod_q    <= wprod_d;
    diff_q     <= diff_d;
    fp_q       <= fp_d;
    start_q    <= start_d;
    docend_q   <= docend_d;
  end

  // token ring: read at accept, written in the update step
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ring_rdata_q <= ring_q[slot_now];
    end
    if (ring_we) begin
      ring_q[slot_eff_q] <= tok_hash;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.fingerprint  = fp_q;
  assign result_o.window_start = start_q;
  assign result_o.document_end = docend_q;

endmodule

`default_nettype wire

### rtl/krf_check.sv
// -----------------------------------------------------------------------------
// krf_check
// Port-level checks for the fingerprint block, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "kgram_rolling_fingerprint_macros.svh"

module krf_check (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [krf_pkg::DATA_W-1:0]    fp_i,
  input wire logic [krf_pkg::COUNT_W-1:0]   start_i,
  input wire logic                          docend_i
);
  import krf_pkg::*;

  // one transaction at a time on the input side
  `KRF_ASSERT_NXT(a_one_item_at_a_time, in_valid_i && in_ready_i, !in_ready_i)

  // a fresh result follows its item by the fixed schedule
  `KRF_ASSERT_IMP(a_result_latency, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 6))

  `KRF_ASSERT_IMP(a_fp_reduced, out_valid_i, fp_i != MOD61)

  `KRF_ASSERT_NXT(a_result_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(fp_i) && $stable(start_i) && $stable(docend_i))

endmodule

bind kgram_rolling_fingerprint krf_check u_krf_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .fp_i        (result_o.fingerprint),
  .start_i     (result_o.window_start),
  .docend_i    (result_o.document_end)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for kgram_rolling_fingerprint. Character
// transactions are sent in directed and random documents while both channels
// stall at random, but for one steady pass. A local mod 2^61-1 model of the
// token hash, token ring and window hash predicts every fingerprint
// transaction, and each one that arrives is compared field by field in order.
// ---------------------------------------------------------------------------
module tb;
  import krf_pkg::*;

  localparam int RING_DEPTH    = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [DATA_W-1:0]  fingerprint;
    logic [COUNT_W-1:0] window_start;
    logic               document_end;
  } fp_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  krf_in_if  item_if ();
  krf_out_if result_if ();

  kgram_rolling_fingerprint #(
    .MAX_WINDOW(RING_DEPTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // model registers and running state
  logic [DATA_W-1:0]  base_reg;
  logic [WLEN_W-1:0]  wlen_reg;
  logic [DATA_W-1:0]  bpow_reg;
  logic [DATA_W-1:0]  tok_hash;
  logic [DATA_W-1:0]  win_hash;
  logic [DATA_W-1:0]  ring_hash [RING_DEPTH];
  int unsigned        ring_pos;
  logic [COUNT_W-1:0] token_count;

  fp_result_t fp_expected_q[$];
  int         errors      = 0;
  int         items_sent  = 0;
  int         idle_cycles = 0;
  bit         steady      = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD61}) s = s - {1'b0, MOD61};
    return s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    return mod_add(a, MOD61 - b);
  endfunction

  function automatic logic [DATA_W-1:0] mod_mul(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [2*DATA_W-1:0] p;
    logic [DATA_W+1:0]   s;
    p = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    s = {2'b00, p[DATA_W-1:0]} + {2'b00, p[2*DATA_W-1:DATA_W]};
    s = {2'b00, s[DATA_W-1:0]} + {{DATA_W{1'b0}}, s[DATA_W+1:DATA_W]};
    if (s >= {2'b00, MOD61}) s = s - {2'b00, MOD61};
    return s[DATA_W-1:0];
  endfunction

  function automatic int unsigned eff_window(input logic [WLEN_W-1:0] w);
    if (w == '0) return 1;
    if (w > RING_DEPTH) return RING_DEPTH;
    return 32'(w);
  endfunction

  function automatic logic [DATA_W-1:0] base_power(input logic [DATA_W-1:0] b,
                                                   input int unsigned k);
    logic [DATA_W-1:0] r;
    r = DATA_W'(1);
    repeat (k) r = mod_mul(r, mod_add(b, '0));
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_residue();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return DATA_W'(r % MOD61);
  endfunction

  task automatic clear_run();
    tok_hash    = '0;
    win_hash    = '0;
    ring_pos    = 0;
    token_count = '0;
  endtask

  task automatic hash_item(input logic [CHAR_W-1:0] code, input logic cv, input logic eot,
                           input logic eod);
    logic [DATA_W-1:0]  b, bk, th, w;
    int unsigned        k, pos;
    logic [COUNT_W-1:0] prior;
    fp_result_t         exp_r;
    b  = mod_add(base_reg, '0);
    bk = mod_add(bpow_reg, '0);
    k  = eff_window(wlen_reg);
    if (cv) tok_hash = mod_add(mod_mul(tok_hash, b), DATA_W'(code) + DATA_W'(1));
    if (eot) begin
      th    = (tok_hash == '0) ? DATA_W'(1) : tok_hash;
      pos   = (ring_pos >= k) ? 0 : ring_pos;
      prior = token_count;
      w     = mod_mul(win_hash, b);
      if (prior >= k) w = mod_sub(w, mod_mul(bk, ring_hash[pos]));
      win_hash       = mod_add(w, th);
      ring_hash[pos] = th;
      ring_pos       = (pos + 1 >= k) ? 0 : pos + 1;
      if (token_count != '1) token_count++;
      tok_hash = '0;
      if (64'(prior) + 1 >= 64'(k)) begin
        exp_r = '{win_hash,
                  (prior == '1) ? prior : prior + COUNT_W'(1) - COUNT_W'(k),
                  eod};
        fp_expected_q = {fp_expected_q, exp_r};
      end
    end
    if (eod) clear_run();
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic cv, input logic eot,
                           input logic eod);
    while (!steady && $urandom_range(99) < 29) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid           <= 1'b1;
    item_if.char_code       <= code;
    item_if.char_valid      <= cv;
    item_if.end_of_token    <= eot;
    item_if.end_of_document <= eod;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    hash_item(code, cv, eot, eod);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_token(input logic [CHAR_W-1:0] code, input logic eod);
    send_char(code, 1'b1, 1'b1, eod);
  endtask

  // drop valid, drain all results, then let any resultless transaction finish
  task automatic settle();
    item_if.valid <= 1'b0;
    while (fp_expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [DATA_W-1:0] base_v, input logic [WLEN_W-1:0] wlen_v,
                           input logic [DATA_W-1:0] bpow_v);
    logic [DATA_W-1:0] wdata;
    wdata               = DATA_W'({$urandom, $urandom});
    wdata[WLEN_W-1:0]   = wlen_v;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BASE;
    cfg_data_i <= base_v;
    @(negedge clk_i);
    cfg_idx_i  <= REG_WINDOW_LEN;
    cfg_data_i <= wdata;
    @(negedge clk_i);
    cfg_idx_i  <= REG_BASE_POW;
    cfg_data_i <= bpow_v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    base_reg = base_v;
    wlen_reg = wlen_v;
    bpow_reg = bpow_v;
  endtask

  task automatic configure_window(input logic [DATA_W-1:0] base_v,
                                  input logic [WLEN_W-1:0] wlen_v);
    configure(base_v, wlen_v, base_power(base_v, eff_window(wlen_v)));
  endtask

  task automatic send_document(input int unsigned k);
    int unsigned tokens, chars;
    bit          cut;
    tokens = (k >= RING_DEPTH) ? $urandom_range(k + 20, k) : $urandom_range(2 * k + 4, 0);
    cut    = ($urandom_range(4) == 0);
    for (int unsigned t = 0; t < tokens; t++) begin
      chars = (k >= RING_DEPTH) ? $urandom_range(1) : $urandom_range(3);
      repeat (chars) send_char(CHAR_W'($urandom), $urandom_range(9) != 0, 1'b0, 1'b0);
      send_char(CHAR_W'($urandom), $urandom_range(3) != 0, 1'b1, !cut && t + 1 == tokens);
    end
    if (cut || tokens == 0) send_char(CHAR_W'($urandom), 1'($urandom_range(1)), 1'b0, 1'b1);
  endtask

  task automatic test_defaults();
    // short document, ends inside a token
    send_token(8'h41, 1'b0);
    send_token(8'h42, 1'b0);
    send_char(8'h43, 1'b1, 1'b0, 1'b1);
    // nine tokens against the reset window of eight
    send_token(8'h00, 1'b0);
    send_token(8'hff, 1'b0);
    send_char(8'h5a, 1'b0, 1'b1, 1'b0);
    send_char(8'h61, 1'b1, 1'b0, 1'b0);
    send_char(8'h7e, 1'b0, 1'b0, 1'b0);
    send_char(8'h62, 1'b1, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) send_token(CHAR_W'(i * 37), 1'b0);
    send_token(8'h80, 1'b1);
    settle();
  endtask

  task automatic test_register_extremes();
    // base of -1: two equal chars hash to zero
    configure(MOD61 - DATA_W'(1), 7'd1, MOD61 - DATA_W'(1));
    send_char(8'h33, 1'b1, 1'b0, 1'b0);
    send_char(8'h33, 1'b1, 1'b1, 1'b0);
    send_token(8'hff, 1'b0);
    send_char(8'h00, 1'b0, 1'b1, 1'b1);
    settle();
    // window length zero acts as one
    configure(DATA_W'(1), 7'd0, '0);
    send_token(8'h01, 1'b0);
    send_token(8'hfe, 1'b0);
    send_token(8'h10, 1'b1);
    settle();
    // all-ones registers act as zero
    configure(MOD61, 7'd2, MOD61);
    send_token(8'h20, 1'b0);
    send_token(8'h21, 1'b0);
    send_token(8'h22, 1'b1);
    settle();
  endtask

  task automatic test_window_shrink();
    logic [DATA_W-1:0] b;
    b = rand_residue();
    configure_window(b, 7'd4);
    repeat (6) send_token(CHAR_W'($urandom), 1'b0);
    settle();
    // ring position is now past the shorter window
    configure_window(b, 7'd2);
    send_token(CHAR_W'($urandom), 1'b0);
    send_token(CHAR_W'($urandom), 1'b0);
    send_token(CHAR_W'($urandom), 1'b1);
    settle();
  endtask

  task automatic test_random_documents();
    logic [DATA_W-1:0] b;
    logic [WLEN_W-1:0] w;
    int                budget, first;
    for (int p = 0; p < 8; p++) begin
      b      = rand_residue();
      budget = 20;
      w      = WLEN_W'($urandom_range(12, 1));
      case (p)
        0: w = 7'd1;
        1: w = 7'd2;
        2: begin
          w      = 7'd3;
          steady = 1'b1;
          budget = 40;
        end
        3: w = WLEN_W'($urandom_range(8, 4));
        4: begin
          w      = 7'd64;
          budget = 60;
        end
        5: begin
          w      = 7'd127;
          budget = 60;
        end
        default: ;
      endcase
      case (p)
        6:       configure('0, w, rand_residue());
        7:       configure(b, w, MOD61);
        default: configure_window(b, w);
      endcase
      first = items_sent;
      while (items_sent - first < budget) send_document(eff_window(w));
      settle();
      steady = 1'b0;
    end
  endtask

  always @(negedge clk_i) begin
    result_if.ready <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk_i) begin
    fp_result_t want;
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (fp_expected_q.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual fingerprint %h start %0d",
                 $time, result_if.fingerprint, result_if.window_start);
        errors++;
      end else begin
        want = fp_expected_q.pop_front();
        if (result_if.fingerprint !== want.fingerprint) begin
          $display("%0t: fingerprint expected %h actual %h", $time, want.fingerprint,
                   result_if.fingerprint);
          errors++;
        end
        if (result_if.window_start !== want.window_start) begin
          $display("%0t: window_start expected %0d actual %0d", $time, want.window_start,
                   result_if.window_start);
          errors++;
        end
        if (result_if.document_end !== want.document_end) begin
          $display("%0t: document_end expected %b actual %b", $time, want.document_end,
                   result_if.document_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = REG_BASE;
    cfg_data_i              = '0;
    item_if.valid           = 1'b0;
    item_if.char_code       = '0;
    item_if.char_valid      = 1'b0;
    item_if.end_of_token    = 1'b0;
    item_if.end_of_document = 1'b0;
    base_reg                = BASE_RST;
    wlen_reg                = WLEN_RST;
    bpow_reg                = BASE_POW_RST;
    clear_run();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_register_extremes();
    test_window_shrink();
    test_random_documents();
    settle();
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
